### hw/rtl/ffsa_pkg.sv
`default_nettype none

package ffsa_pkg;

	// fixed field widths
	localparam int unsigned OFS_W = 10;
	localparam int unsigned LEN_W = 11;
	localparam int unsigned STS_W = 2;

	// largest region in units
	localparam int unsigned MEM_UNITS = 1024;
	localparam int unsigned MAX_SEGMENTS_DEF = 64;

	// operation codes
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// status codes
	localparam logic [STS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STS_W-1:0] ST_NOFIT    = 2'd1;
	localparam logic [STS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STS_W-1:0] ST_NOTFOUND = 2'd3;

	// one table entry
	typedef struct packed {
		logic [OFS_W-1:0] start;
		logic [LEN_W-1:0] len;
		logic             used;
	} seg_t;

endpackage

`default_nettype wire

### hw/rtl/ffsa_if.sv
`default_nettype none

// command channel
interface ffsa_cmd_if;
	logic                       valid;
	logic                       ready;
	logic                       func;
	logic [ffsa_pkg::LEN_W-1:0] request_size;
	logic [ffsa_pkg::OFS_W-1:0] block_offset;

	modport source (output valid, func, request_size, block_offset, input ready);
	modport sink (input valid, func, request_size, block_offset, output ready);
endinterface

// response channel
interface ffsa_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [ffsa_pkg::OFS_W-1:0] granted_offset;
	logic [ffsa_pkg::STS_W-1:0] status;

	modport source (output valid, granted_offset, status, input ready);
	modport sink (input valid, granted_offset, status, output ready);
endinterface

`default_nettype wire

### hw/rtl/first_fit_segment_allocator.sv
`default_nettype none
// response time: a zero-size allocate is answered straight from idle; other commands depend on
//   n = live segments, through the walk of the segment table memory (one read, one write port)
// throughput: one transaction in flight; the next is taken in the cycle its result is accepted
// reset: table holds one free segment of total_size (1024); the init state, entered after reset
//   and after each total_size write, writes entry zero before a command is taken
module first_fit_segment_allocator #(
	parameter int unsigned MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_we,
	input  wire [ffsa_pkg::LEN_W-1:0]  cfg_wdata,
	ffsa_cmd_if.sink                   cmd,
	ffsa_rsp_if.source                 rsp
);
	import ffsa_pkg::*;

	localparam int unsigned IW = $clog2(MAX_SEGMENTS);
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
	localparam int unsigned PW = CW + 1;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SEARCH, S_ASHIFT, S_AWR1, S_AWR2,
		S_FRDR, S_FRDL, S_FMRG, S_FSHIFT
	} state_t;

	state_t             state_q;
	logic [LEN_W-1:0]   total_q;
	logic [CW-1:0]      count_q;
	logic [PW-1:0]      ptr_q;
	logic [IW-1:0]      hit_q;
	seg_t               hdat_q;
	seg_t               rdat_q;
	logic               rfree_q;
	logic [1:0]         dist_q;
	logic               func_q;
	logic [LEN_W-1:0]   req_q;
	logic [OFS_W-1:0]   off_q;
	logic               out_vld_q;
	logic [OFS_W-1:0]   granted_q;
	logic [STS_W-1:0]   status_q;
	logic               rvld_s1;
	logic [IW-1:0]      ridx_s1;
	seg_t               rdata_s1;

	seg_t               mem_q [MAX_SEGMENTS];

	logic               ren;
	logic [IW-1:0]      raddr;
	logic               we;
	logic [IW-1:0]      waddr;
	seg_t               wdata;
	logic               match;
	logic               last;
	logic               cmd_ready;
	logic [LEN_W-1:0]   cfg_val;
	logic [PW-1:0]      hitp1;
	logic [PW-1:0]      cnt_p;
	logic               lfree;
	logic [IW-1:0]      mw;
	seg_t               mval;
	logic [1:0]         mdist;
	logic [PW-1:0]      msrc;
	logic [LEN_W-1:0]   rlen;

	// clamp of the region size
	always_comb begin
		if (cfg_wdata == '0)
			cfg_val = LEN_W'(1);
		else if (cfg_wdata > LEN_W'(MEM_UNITS))
			cfg_val = LEN_W'(MEM_UNITS);
		else
			cfg_val = cfg_wdata;
	end

	assign hitp1 = PW'(hit_q) + PW'(1);
	assign cnt_p = PW'(count_q);

	// search compare on returned entry
	assign match = (func_q == FUNC_FREE) ?
		(rdata_s1.used && rdata_s1.start == off_q) :
		(!rdata_s1.used && rdata_s1.len > req_q);
	assign last = (PW'(ridx_s1) + PW'(1)) == cnt_p;

	// merge of freed segment with its neighbors
	always_comb begin
		lfree = rvld_s1 && !rdata_s1.used;
		rlen  = rfree_q ? rdat_q.len : '0;
		msrc  = hitp1 + PW'(rfree_q);
		if (lfree) begin
			mw         = hit_q - IW'(1);
			mval.start = rdata_s1.start;
			mval.len   = rdata_s1.len + hdat_q.len + rlen;
			mdist      = rfree_q ? 2'd2 : 2'd1;
		end else begin
			mw         = hit_q;
			mval.start = hdat_q.start;
			mval.len   = hdat_q.len + rlen;
			mdist      = rfree_q ? 2'd1 : 2'd0;
		end
		mval.used = 1'b0;
	end

	// memory port control
	always_comb begin
		ren   = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		case (state_q)
			S_INIT: begin
				we        = 1'b1;
				wdata.len = total_q;
			end
			S_SEARCH: begin
				if (ptr_q < cnt_p && !(rvld_s1 && (match || last))) begin
					ren   = 1'b1;
					raddr = ptr_q[IW-1:0];
				end
			end
			S_ASHIFT: begin
				if (ptr_q > hitp1) begin
					ren   = 1'b1;
					raddr = IW'(ptr_q - PW'(1));
				end
				if (rvld_s1) begin
					we    = 1'b1;
					waddr = ridx_s1 + IW'(1);
					wdata = rdata_s1;
				end
			end
			S_AWR1: begin
				we          = 1'b1;
				waddr       = hit_q + IW'(1);
				wdata.start = OFS_W'({1'b0, hdat_q.start} + req_q);
				wdata.len   = hdat_q.len - req_q;
				wdata.used  = 1'b0;
			end
			S_AWR2: begin
				we          = 1'b1;
				waddr       = hit_q;
				wdata.start = hdat_q.start;
				wdata.len   = req_q;
				wdata.used  = 1'b1;
			end
			S_FRDR: begin
				if (hitp1 < cnt_p) begin
					ren   = 1'b1;
					raddr = hit_q + IW'(1);
				end
			end
			S_FRDL: begin
				if (hit_q != '0) begin
					ren   = 1'b1;
					raddr = hit_q - IW'(1);
				end
			end
			S_FMRG: begin
				we    = 1'b1;
				waddr = mw;
				wdata = mval;
			end
			S_FSHIFT: begin
				if (ptr_q < cnt_p) begin
					ren   = 1'b1;
					raddr = ptr_q[IW-1:0];
				end
				if (rvld_s1) begin
					we    = 1'b1;
					waddr = ridx_s1 - IW'(dist_q);
					wdata = rdata_s1;
				end
			end
			default: ;
		endcase
	end

	// segment table memory
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (ren)
			rdata_s1 <= mem_q[raddr];
	end

	assign cmd_ready          = (state_q == S_IDLE) && (!out_vld_q || rsp.ready);
	assign cmd.ready          = cmd_ready;
	assign rsp.valid          = out_vld_q;
	assign rsp.granted_offset = granted_q;
	assign rsp.status         = status_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			total_q   <= LEN_W'(MEM_UNITS);
			count_q   <= CW'(1);
			ptr_q     <= '0;
			hit_q     <= '0;
			hdat_q    <= '0;
			rdat_q    <= '0;
			rfree_q   <= 1'b0;
			dist_q    <= '0;
			func_q    <= 1'b0;
			req_q     <= '0;
			off_q     <= '0;
			out_vld_q <= 1'b0;
			granted_q <= '0;
			status_q  <= ST_OK;
			rvld_s1   <= 1'b0;
			ridx_s1   <= '0;
		end else begin
			rvld_s1 <= ren;
			ridx_s1 <= raddr;
			if (out_vld_q && rsp.ready)
				out_vld_q <= 1'b0;
			if (cfg_we) begin
				total_q <= cfg_val;
				state_q <= S_INIT;
			end else begin
				case (state_q)
					S_INIT: begin
						count_q <= CW'(1);
						state_q <= S_IDLE;
					end
					S_IDLE: begin
						if (cmd.valid && cmd_ready) begin
							func_q <= cmd.func;
							req_q  <= cmd.request_size;
							off_q  <= cmd.block_offset;
							ptr_q  <= '0;
							if (cmd.func == FUNC_ALLOC && cmd.request_size == '0) begin
								out_vld_q <= 1'b1;
								granted_q <= '0;
								status_q  <= ST_NOFIT;
							end else begin
								state_q <= S_SEARCH;
							end
						end
					end
					S_SEARCH: begin
						if (ren)
							ptr_q <= ptr_q + PW'(1);
						if (rvld_s1 && match) begin
							hit_q  <= ridx_s1;
							hdat_q <= rdata_s1;
							if (func_q == FUNC_FREE) begin
								state_q <= S_FRDR;
							end else if (count_q == CW'(MAX_SEGMENTS)) begin
								out_vld_q <= 1'b1;
								granted_q <= '0;
								status_q  <= ST_FULL;
								state_q   <= S_IDLE;
							end else begin
								ptr_q   <= cnt_p;
								state_q <= S_ASHIFT;
							end
						end else if (rvld_s1 && last) begin
							out_vld_q <= 1'b1;
							granted_q <= '0;
							status_q  <= (func_q == FUNC_FREE) ? ST_NOTFOUND : ST_NOFIT;
							state_q   <= S_IDLE;
						end
					end
					S_ASHIFT: begin
						if (ren)
							ptr_q <= ptr_q - PW'(1);
						if (!ren && !rvld_s1)
							state_q <= S_AWR1;
					end
					S_AWR1: state_q <= S_AWR2;
					S_AWR2: begin
						count_q   <= count_q + CW'(1);
						out_vld_q <= 1'b1;
						granted_q <= hdat_q.start;
						status_q  <= ST_OK;
						state_q   <= S_IDLE;
					end
					S_FRDR: state_q <= S_FRDL;
					S_FRDL: begin
						rfree_q <= rvld_s1 && !rdata_s1.used;
						rdat_q  <= rdata_s1;
						state_q <= S_FMRG;
					end
					S_FMRG: begin
						if (mdist == 2'd0) begin
							out_vld_q <= 1'b1;
							granted_q <= '0;
							status_q  <= ST_OK;
							state_q   <= S_IDLE;
						end else begin
							ptr_q   <= msrc;
							dist_q  <= mdist;
							state_q <= S_FSHIFT;
						end
					end
					S_FSHIFT: begin
						if (ren)
							ptr_q <= ptr_q + PW'(1);
						if (!ren && !rvld_s1) begin
							count_q   <= count_q - CW'(dist_q);
							out_vld_q <= 1'b1;
							granted_q <= '0;
							status_q  <= ST_OK;
							state_q   <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule

`default_nettype wire
